// File: rtl/mlp_pkg.sv
package mlp_pkg;

    localparam int MAX_INPUTS  = 1024;
    localparam int MAX_WIDTH   = 64;
    localparam int MAX_HIDDEN  = 4;
    localparam int CLASS_COUNT = 10;

    localparam int IN_AW   = $clog2(MAX_INPUTS);
    localparam int W_AW    = $clog2(MAX_WIDTH);
    localparam int CLS_W   = $clog2(CLASS_COUNT);
    localparam int LAYER_W = $clog2(MAX_HIDDEN + 1);
    localparam int HID_DEPTH = (MAX_HIDDEN - 1) * MAX_WIDTH * MAX_WIDTH;
    localparam int HID_AW  = $clog2(HID_DEPTH);
    localparam int OW_DEPTH = MAX_WIDTH * CLASS_COUNT;
    localparam int OW_AW   = $clog2(OW_DEPTH);

    localparam int SIG_SIZE = 1024;
    localparam int SIG_AW   = $clog2(SIG_SIZE);
    localparam int SCORE_W  = 13;
    localparam int ACC_W    = 40;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [SCORE_W-1:0] SCORE_ONE  = 13'd4096;
    localparam logic [SCORE_W-1:0] SCORE_HALF = 13'd2048;
    localparam logic [9:0] LEAK_SLOPE = 10'd410;

    localparam logic [1:0] ACT_WEIGHT   = 2'd0;
    localparam logic [1:0] ACT_PIXEL    = 2'd1;
    localparam logic [1:0] ACT_CLASSIFY = 2'd2;

    localparam logic [1:0] REG_INPUT_COUNT  = 2'd0;
    localparam logic [1:0] REG_HIDDEN_WIDTH = 2'd1;
    localparam logic [1:0] REG_LAYER_COUNT  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLR,
        ST_MAC,
        ST_DRAIN,
        ST_ROUND,
        ST_ACT,
        ST_SCORE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic               load;
        logic               start;
        logic               clr_acc;
        logic               issue;
        logic               round;
        logic               act;
        logic               score;
        logic               emit;
        logic               is_out;
        logic [LAYER_W-1:0] layer;
        logic [IN_AW-1:0]   src;
        logic [W_AW-1:0]    dst;
    } ctrl_cmd_t;

    typedef struct packed {
        logic busy;
        logic out_full;
    } dp_status_t;

    typedef logic [SCORE_W-1:0] sig_table_t [SIG_SIZE];

    function automatic sig_table_t build_sig_table();
        sig_table_t t;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] num;
        logic [63:0] rem;
        logic [63:0] quo;
        for (int k = 0; k < SIG_SIZE; k++)
        begin
            t[k] = '0;
        end
        e = 64'd1 << 30;
        for (int k = 0; k <= SIG_SIZE / 2; k++)
        begin
            den = (64'd1 << 30) + e;
            num = (64'd1 << 42) + (den >> 1);
            rem = '0;
            quo = '0;
            for (int b = 43; b >= 0; b--)
            begin
                rem = {rem[62:0], num[b]};
                quo = {quo[62:0], 1'b0};
                if (rem >= den)
                begin
                    rem = rem - den;
                    quo[0] = 1'b1;
                end
            end
            if (k < SIG_SIZE / 2)
            begin
                t[SIG_SIZE / 2 + k] = quo[SCORE_W-1:0];
            end
            if (k > 0)
            begin
                t[SIG_SIZE / 2 - k] = SCORE_ONE - quo[SCORE_W-1:0];
            end
            e = (e * 64'd1057095000) >> 30;
        end
        return t;
    endfunction

    localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

// File: rtl/mlp_if.sv
interface mlp_item_if;
    import mlp_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [1:0]             action;
    logic [2:0]             layer_select;
    logic [IN_AW-1:0]       source_index;
    logic [W_AW-1:0]        dest_index;
    logic signed [15:0]     data_value;
    logic [3:0]             true_label;

    modport source (output valid, action, layer_select, source_index, dest_index,
                    data_value, true_label, input ready);
    modport sink (input valid, action, layer_select, source_index, dest_index,
                  data_value, true_label, output ready);
endinterface

interface mlp_result_if;
    import mlp_pkg::*;
    logic                   valid;
    logic                   ready;
    logic signed [4:0]      predicted_class;
    logic [SCORE_W-1:0]     best_score;

    modport source (output valid, predicted_class, best_score, input ready);
    modport sink (input valid, predicted_class, best_score, output ready);
endinterface

// File: rtl/mlp_ctrl.sv
module mlp_ctrl
    import mlp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        item_valid,
    input  logic [1:0]  item_action,
    output logic        item_ready,
    input  dp_status_t  status,
    output ctrl_cmd_t   cmd
);

    state_t             state_reg, state_next;
    logic [10:0]        in_count_reg;
    logic [6:0]         width_reg;
    logic [2:0]         layers_reg;
    logic [LAYER_W-1:0] layer_reg, layer_next;
    logic [IN_AW-1:0]   src_reg, src_next;
    logic [W_AW-1:0]    dst_reg, dst_next;

    logic [10:0]        n_in;
    logic [6:0]         n_w;
    logic [LAYER_W-1:0] n_h;
    logic [10:0]        n_src;
    logic [6:0]         n_dst;
    logic               is_out;
    logic               accept;
    logic               src_last;
    logic               dst_last;

    assign n_in = (in_count_reg > 11'(MAX_INPUTS)) ? 11'(MAX_INPUTS) : in_count_reg;
    assign n_w  = (width_reg > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : width_reg;
    assign n_h  = (layers_reg == 3'd0) ? LAYER_W'(1) :
                  ((layers_reg > 3'(MAX_HIDDEN)) ? LAYER_W'(MAX_HIDDEN) : LAYER_W'(layers_reg));
    assign is_out   = (layer_reg == n_h);
    assign n_src    = (layer_reg == '0) ? n_in : 11'(n_w);
    assign n_dst    = is_out ? 7'(CLASS_COUNT) : n_w;
    assign src_last = ((11'(src_reg) + 11'd1) == n_src);
    assign dst_last = ((7'(dst_reg) + 7'd1) == n_dst);
    assign accept   = item_valid && item_ready;
    assign item_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_count_reg <= 11'd784;
            width_reg    <= 7'd64;
            layers_reg   <= 3'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_INPUT_COUNT:  in_count_reg <= cfg_data;
                REG_HIDDEN_WIDTH: width_reg    <= cfg_data[6:0];
                REG_LAYER_COUNT:  layers_reg   <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            layer_reg <= '0;
            src_reg   <= '0;
            dst_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            layer_reg <= layer_next;
            src_reg   <= src_next;
            dst_reg   <= dst_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        layer_next = layer_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && item_action == ACT_CLASSIFY)
                begin
                    state_next = ST_CLR;
                    layer_next = (n_w == '0) ? n_h : '0;
                    dst_next   = '0;
                end
            end
            ST_CLR:
            begin
                src_next   = '0;
                state_next = (n_src == '0) ? ST_DRAIN : ST_MAC;
            end
            ST_MAC:
            begin
                src_next = src_reg + IN_AW'(1);
                if (src_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.busy)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                state_next = ST_ACT;
            end
            ST_ACT:
            begin
                if (is_out)
                begin
                    state_next = ST_SCORE;
                end
                else if (dst_last)
                begin
                    layer_next = layer_reg + LAYER_W'(1);
                    dst_next   = '0;
                    state_next = ST_CLR;
                end
                else
                begin
                    dst_next   = dst_reg + W_AW'(1);
                    state_next = ST_CLR;
                end
            end
            ST_SCORE:
            begin
                if (dst_last)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    dst_next   = dst_reg + W_AW'(1);
                    state_next = ST_CLR;
                end
            end
            ST_EMIT:
            begin
                if (!status.out_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.load    = accept;
        cmd.start   = accept && (item_action == ACT_CLASSIFY);
        cmd.is_out  = is_out;
        cmd.layer   = layer_reg;
        cmd.src     = src_reg;
        cmd.dst     = dst_reg;
        unique case (state_reg)
            ST_CLR:   cmd.clr_acc = 1'b1;
            ST_MAC:   cmd.issue   = 1'b1;
            ST_ROUND: cmd.round   = 1'b1;
            ST_ACT:   cmd.act     = 1'b1;
            ST_SCORE: cmd.score   = 1'b1;
            ST_EMIT:  cmd.emit    = !status.out_full;
            default: ;
        endcase
    end

endmodule

// File: rtl/mlp_dp.sv
module mlp_dp
    import mlp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  ctrl_cmd_t                 cmd,
    output dp_status_t                status,
    input  logic [1:0]                action,
    input  logic [2:0]                layer_select,
    input  logic [IN_AW-1:0]          source_index,
    input  logic [W_AW-1:0]           dest_index,
    input  logic signed [15:0]        data_value,
    input  logic [3:0]                true_label,
    output logic                      result_valid,
    input  logic                      result_ready,
    output logic signed [4:0]         predicted_class,
    output logic [SCORE_W-1:0]        best_score
);

    logic signed [15:0] iw_mem   [MAX_INPUTS * MAX_WIDTH];
    logic signed [15:0] hw_mem   [HID_DEPTH];
    logic signed [15:0] ow_mem   [OW_DEPTH];
    logic signed [15:0] px_mem   [MAX_INPUTS];
    logic signed [15:0] ping_mem [MAX_WIDTH];
    logic signed [15:0] pong_mem [MAX_WIDTH];

    logic signed [15:0] iw_rd_reg, hw_rd_reg, ow_rd_reg, px_rd_reg, ping_rd_reg, pong_rd_reg;
    logic               v1_reg, v2_reg;
    logic               pix_sel_reg, pong_sel_reg;
    logic [1:0]         wsel_reg;
    logic signed [31:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [15:0] q_reg;
    logic [SCORE_W-1:0] sig_reg;
    logic [SCORE_W-1:0] best_reg;
    logic [CLS_W-1:0]   pred_reg;
    logic               found_reg, reject_reg;
    logic [3:0]         label_reg;
    logic               out_valid_reg;
    logic signed [4:0]  out_class_reg;
    logic [SCORE_W-1:0] out_score_reg;

    logic [LAYER_W-1:0] seg_w, layer_m1;
    logic               hid_layer;
    logic [15:0]        iw_waddr, iw_raddr;
    logic [HID_AW-1:0]  hw_waddr, hw_raddr;
    logic [OW_AW-1:0]   ow_waddr, ow_raddr;
    logic               we_iw, we_hw, we_ow, we_px;
    logic signed [15:0] mul_a, mul_b;
    logic signed [ACC_W:0] acc_sum;
    logic signed [ACC_W:0] rnd_sum;
    logic signed [ACC_W-12:0] rnd_sh;
    logic signed [15:0] q_sat;
    logic signed [26:0] leak_p;
    logic signed [15:0] leak_y;
    logic [SIG_AW-1:0]  sig_idx;
    logic               dst_is_label;

    assign seg_w    = LAYER_W'(layer_select) - LAYER_W'(1);
    assign layer_m1 = cmd.layer - LAYER_W'(1);
    assign hid_layer = (cmd.layer != '0) && !cmd.is_out;

    assign iw_waddr = {source_index, dest_index};
    assign hw_waddr = HID_AW'({seg_w, source_index[W_AW-1:0], dest_index});
    assign ow_waddr = OW_AW'(source_index[W_AW-1:0]) * OW_AW'(CLASS_COUNT)
                      + OW_AW'(dest_index);
    assign iw_raddr = {cmd.src, cmd.dst};
    assign hw_raddr = HID_AW'({layer_m1, cmd.src[W_AW-1:0], cmd.dst});
    assign ow_raddr = OW_AW'(cmd.src[W_AW-1:0]) * OW_AW'(CLASS_COUNT) + OW_AW'(cmd.dst);

    always_comb
    begin
        we_iw = 1'b0;
        we_hw = 1'b0;
        we_ow = 1'b0;
        we_px = cmd.load && (action == ACT_PIXEL);
        if (cmd.load && action == ACT_WEIGHT)
        begin
            priority if (layer_select == 3'd0)
            begin
                we_iw = 1'b1;
            end
            else if (layer_select < 3'(MAX_HIDDEN))
            begin
                we_hw = (source_index < IN_AW'(MAX_WIDTH));
            end
            else if (layer_select == 3'(MAX_HIDDEN))
            begin
                we_ow = (source_index < IN_AW'(MAX_WIDTH))
                        && (dest_index < W_AW'(CLASS_COUNT));
            end
            else
            begin
                we_ow = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_iw)
        begin
            iw_mem[iw_waddr] <= data_value;
        end
        if (cmd.issue && cmd.layer == '0)
        begin
            iw_rd_reg <= iw_mem[iw_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_hw)
        begin
            hw_mem[hw_waddr] <= data_value;
        end
        if (cmd.issue && hid_layer)
        begin
            hw_rd_reg <= hw_mem[hw_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_ow)
        begin
            ow_mem[ow_waddr] <= data_value;
        end
        if (cmd.issue && cmd.is_out)
        begin
            ow_rd_reg <= ow_mem[ow_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_px)
        begin
            px_mem[source_index] <= data_value;
        end
        if (cmd.issue && cmd.layer == '0)
        begin
            px_rd_reg <= px_mem[cmd.src];
        end
    end

    // ping is written by even hidden layers, pong by odd; layers after the first read the other one
    always_ff @(posedge clk)
    begin
        if (cmd.act && !cmd.is_out && !cmd.layer[0])
        begin
            ping_mem[cmd.dst] <= leak_y;
        end
        if (cmd.issue && cmd.layer[0])
        begin
            ping_rd_reg <= ping_mem[cmd.src[W_AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.act && !cmd.is_out && cmd.layer[0])
        begin
            pong_mem[cmd.dst] <= leak_y;
        end
        if (cmd.issue && cmd.layer != '0 && !cmd.layer[0])
        begin
            pong_rd_reg <= pong_mem[cmd.src[W_AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            pix_sel_reg  <= (cmd.layer == '0);
            pong_sel_reg <= !cmd.layer[0];
            wsel_reg     <= (cmd.layer == '0) ? 2'd0 : (cmd.is_out ? 2'd2 : 2'd1);
        end
    end

    always_comb
    begin
        mul_a = pix_sel_reg ? px_rd_reg : (pong_sel_reg ? pong_rd_reg : ping_rd_reg);
        unique case (wsel_reg)
            2'd0:    mul_b = iw_rd_reg;
            2'd1:    mul_b = hw_rd_reg;
            default: mul_b = ow_rd_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            prod_reg <= mul_a * mul_b;
        end
    end

    assign acc_sum = (ACC_W+1)'(acc_reg) + (ACC_W+1)'(prod_reg);

    assign rnd_sum = (ACC_W+1)'(acc_reg) + (ACC_W+1)'(2048);
    assign rnd_sh  = rnd_sum[ACC_W:12];
    assign q_sat   = (rnd_sh > (ACC_W-11)'(32767)) ? 16'sh7FFF :
                     ((rnd_sh < -(ACC_W-11)'(32768)) ? 16'sh8000 : rnd_sh[15:0]);

    assign leak_p  = 27'(q_reg) * $signed({1'b0, LEAK_SLOPE}) + 27'sd2048;
    assign leak_y  = (q_reg > 16'sd0) ? q_reg : 16'(leak_p >>> 12);
    assign sig_idx = {~q_reg[15], q_reg[14:6]};
    assign dst_is_label = (cmd.dst == W_AW'(label_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            acc_reg <= '0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            if (cmd.clr_acc)
            begin
                acc_reg <= '0;
            end
            else if (v2_reg)
            begin
                if (acc_sum > (ACC_W+1)'(ACC_MAX))
                begin
                    acc_reg <= ACC_MAX;
                end
                else if (acc_sum < (ACC_W+1)'(ACC_MIN))
                begin
                    acc_reg <= ACC_MIN;
                end
                else
                begin
                    acc_reg <= acc_sum[ACC_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.round)
        begin
            q_reg <= q_sat;
        end
        if (cmd.act && cmd.is_out)
        begin
            sig_reg <= SIG_TABLE[sig_idx];
        end
        if (cmd.load)
        begin
            label_reg <= true_label;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg   <= SCORE_HALF;
            pred_reg   <= '0;
            found_reg  <= 1'b0;
            reject_reg <= 1'b0;
        end
        else if (cmd.start)
        begin
            best_reg   <= SCORE_HALF;
            pred_reg   <= '0;
            found_reg  <= 1'b0;
            reject_reg <= 1'b0;
        end
        else if (cmd.score)
        begin
            if ((sig_reg == SCORE_ONE && !dst_is_label) || (sig_reg == '0 && dst_is_label))
            begin
                reject_reg <= 1'b1;
            end
            if (sig_reg > best_reg)
            begin
                best_reg  <= sig_reg;
                pred_reg  <= cmd.dst[CLS_W-1:0];
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_class_reg <= '0;
            out_score_reg <= '0;
        end
        else
        begin
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
                if (found_reg && !reject_reg)
                begin
                    out_class_reg <= 5'(pred_reg);
                    out_score_reg <= best_reg;
                end
                else
                begin
                    out_class_reg <= -5'sd1;
                    out_score_reg <= '0;
                end
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.busy     = v1_reg || v2_reg;
    assign status.out_full = out_valid_reg && !result_ready;
    assign result_valid    = out_valid_reg;
    assign predicted_class = out_class_reg;
    assign best_score      = out_score_reg;

endmodule

// File: rtl/mlp_inference_classifier.sv
// Weight and pixel transactions: one per cycle while idle, written on acceptance.
// Classify: per node, clear the accumulator, issue its terms (none for an empty sum), drain,
// round and activate; output nodes are then scored, and the result is emitted once no held
// result blocks it. A single multiply-accumulate unit walks each sum one term a cycle.
// Reset (rst_n, async low) clears control and sets config to defaults; weight, pixel and
// activation memories hold unknown contents until written.
module mlp_inference_classifier
    import mlp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [10:0]   cfg_data,
    mlp_item_if.sink      item,
    mlp_result_if.source  result
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    mlp_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .item_valid  (item.valid),
        .item_action (item.action),
        .item_ready  (item.ready),
        .status      (status),
        .cmd         (cmd)
    );

    mlp_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .action          (item.action),
        .layer_select    (item.layer_select),
        .source_index    (item.source_index),
        .dest_index      (item.dest_index),
        .data_value      (item.data_value),
        .true_label      (item.true_label),
        .result_valid    (result.valid),
        .result_ready    (result.ready),
        .predicted_class (result.predicted_class),
        .best_score      (result.best_score)
    );

    a_classify_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready && item.action == ACT_CLASSIFY) |=> !item.ready)
        else $error("classify transaction did not block input");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.predicted_class == -5'sd1) |-> (result.best_score == '0))
        else $error("rejected result carries a score");

    a_class_above_half: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.predicted_class != -5'sd1) |->
        (result.best_score > SCORE_HALF))
        else $error("chosen class not above one half");

endmodule
